@@ rtl/abfb_pkg.sv @@
// Shared types and constants for the alpha blend frame buffer core.
package abfb_pkg;

   // Default frame store bounds.
   localparam int unsigned MAX_WIDTH_DEF  = 256;
   localparam int unsigned MAX_HEIGHT_DEF = 256;

   // Size registers and their reset value.
   localparam int unsigned SIZE_W          = 9;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
   localparam int unsigned CSR_INDEX_W     = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

   // Request kinds.
   localparam logic KIND_BLEND = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Floor division by 255 for values below 65536: (s * RECIP_255) >> RECIP_SHIFT.
   localparam logic [31:0] RECIP_255   = 32'd32897;
   localparam int unsigned RECIP_SHIFT = 23;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_WIPE,
      ST_IDLE,
      ST_ADDR,
      ST_READ,
      ST_WEIGHT,
      ST_NUM,
      ST_DIV,
      ST_FILL,
      ST_RESULT
   } state_type;

   // Color channel being divided.
   typedef enum logic [1:0] {
      CH_BLUE,
      CH_GREEN,
      CH_RED
   } chan_type;

endpackage

@@ rtl/alpha_blend_framebuffer_core.sv @@
// Frame store with source-over alpha blending, clipping and screen clear.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_tvalid/req_tready  tuser: kind; tdata: x, y, r, g, b, a
//   rsp_      out        rsp_tvalid/rsp_tready  tuser: in_bounds; tdata: a, r, g, b
//   csr_      in         csr_we                 csr_index, csr_wdata
//
// An in-frame blend runs from one accepted request to the next through address,
// memory read, weights, per color channel the numerator and the divider steps
// (two quotient bits each), write back and idle. Both alphas zero skip the divider;
// a clipped blend goes straight to the result, and a clear writes width*height pixels,
// one store write per cycle. Reset and every size write zero the whole store, and no
// request is taken meanwhile. A result waiting on rsp_tready stalls only the write back.
module alpha_blend_framebuffer_core
   import abfb_pkg::*;
#(
   parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [63:0]            req_tdata,  // pos_x, pos_y, src_red, src_green,
                                              // src_blue, src_opacity
   input  logic                   req_tuser,  // kind
   // Result channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,  // new_alpha, new_red, new_green, new_blue
   output logic                   rsp_tuser,  // in_bounds
   // Configuration port.
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]      csr_wdata
);

   localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW    = $clog2(DEPTH + 1);
   localparam int unsigned XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int unsigned WDW   = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HDW   = $clog2(MAX_HEIGHT + 1);

   // Pixel store: alpha 7:0, blue 15:8, green 23:16, red 31:24.
   logic [31:0]     mem [DEPTH];
   logic [31:0]     rd_data_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [31:0]     mem_wdata;

   // Control registers.
   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [SIZE_W-1:0] width_ff, width_in;
   logic [SIZE_W-1:0] height_ff, height_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [CW-1:0]   fill_n_ff, fill_n_in;
   logic            kind_ff, kind_in;
   logic            inb_ff, inb_in;
   logic [7:0]      sa_ff, sa_in, sr_ff, sr_in, sg_ff, sg_in, sb_ff, sb_in;
   logic [XW-1:0]   x_ff, x_in;
   logic [YW-1:0]   y_ff, y_in;
   logic [AW-1:0]   addr_ff, addr_in;
   logic [15:0]     ws_ff, ws_in, wd_ff, wd_in, s_ff, s_in;
   logic [15:0]     rem_ff, rem_in;
   logic [7:0]      bits_ff, bits_in;
   logic [7:0]      q_ff, q_in;
   logic [1:0]      step_ff, step_in;
   chan_type        chan_ff, chan_in;
   logic [7:0]      nb_ff, nb_in, ng_ff, ng_in, nr_ff, nr_in;
   logic [31:0]     rsp_data_ff, rsp_data_in;
   logic            rsp_user_ff, rsp_user_in;

   // Combinational helpers.
   logic [WDW-1:0]  eff_w;
   logic [HDW-1:0]  eff_h;
   logic            clipped;
   logic [31:0]     idx_full;
   logic [31:0]     area_full;
   logic [15:0]     s_sum;
   logic [7:0]      c_sel, d_sel;
   logic [23:0]     num;
   logic [16:0]     r1, r2;
   logic            qa, qb;
   logic [31:0]     na_full;
   logic            out_free;
   logic [31:0]     src_px;

   assign req_tready = (state_ff == ST_IDLE) && !csr_we;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Effective size and clipping of the incoming request.
   always_comb begin
      if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = WDW'(MAX_WIDTH);
      end else begin
         eff_w = WDW'(width_ff);
      end
      if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = HDW'(MAX_HEIGHT);
      end else begin
         eff_h = HDW'(height_ff);
      end
      clipped = req_tdata[15] || req_tdata[31] ||
                (32'(req_tdata[14:0]) >= 32'(eff_w)) ||
                (32'(req_tdata[30:16]) >= 32'(eff_h));
      idx_full  = 32'(y_ff) * 32'(eff_w) + 32'(x_ff);
      area_full = 32'(eff_w) * 32'(eff_h);
   end

   // Channel operands, numerator and the two divider steps of one cycle.
   always_comb begin
      case (chan_ff)
         CH_BLUE: begin
            c_sel = sb_ff;
            d_sel = rd_data_ff[15:8];
         end
         CH_GREEN: begin
            c_sel = sg_ff;
            d_sel = rd_data_ff[23:16];
         end
         CH_RED: begin
            c_sel = sr_ff;
            d_sel = rd_data_ff[31:24];
         end
         default: begin
            c_sel = 8'd0;
            d_sel = 8'd0;
         end
      endcase
      s_sum = ws_ff + wd_ff;
      num   = 24'(c_sel) * 24'(ws_ff) + 24'(d_sel) * 24'(wd_ff);

      r1 = {rem_ff, bits_ff[7]};
      qa = (r1 >= {1'b0, s_ff});
      if (qa) begin
         r1 = r1 - {1'b0, s_ff};
      end
      r2 = {r1[15:0], bits_ff[6]};
      qb = (r2 >= {1'b0, s_ff});
      if (qb) begin
         r2 = r2 - {1'b0, s_ff};
      end

      na_full  = 32'(s_ff) * RECIP_255;
      out_free = !rsp_valid_ff || rsp_tready;
      src_px   = {sr_ff, sg_ff, sb_ff, sa_ff};
   end

   // Sequencer: next state, datapath loads and store write port.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      rsp_valid_in = rsp_valid_ff;
      fill_n_in    = fill_n_ff;
      kind_in      = kind_ff;
      inb_in       = inb_ff;
      sa_in        = sa_ff;
      sr_in        = sr_ff;
      sg_in        = sg_ff;
      sb_in        = sb_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      addr_in      = addr_ff;
      ws_in        = ws_ff;
      wd_in        = wd_ff;
      s_in         = s_ff;
      rem_in       = rem_ff;
      bits_in      = bits_ff;
      q_in         = q_ff;
      step_in      = step_ff;
      chan_in      = chan_ff;
      nb_in        = nb_ff;
      ng_in        = ng_ff;
      nr_in        = nr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff[AW-1:0];
      mem_wdata    = 32'd0;

      // The consumer drains the result register.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_WIPE: begin
            if (cnt_ff == CW'(DEPTH)) begin
               state_in = ST_IDLE;
            end else begin
               mem_we = 1'b1;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               kind_in = req_tuser;
               sr_in   = req_tdata[39:32];
               sg_in   = req_tdata[47:40];
               sb_in   = req_tdata[55:48];
               sa_in   = req_tdata[63:56];
               x_in    = req_tdata[XW-1:0];
               y_in    = req_tdata[16 +: YW];
               if (req_tuser == KIND_CLEAR) begin
                  inb_in    = 1'b1;
                  fill_n_in = CW'(area_full);
                  cnt_in    = '0;
                  state_in  = ST_FILL;
               end else if (clipped) begin
                  inb_in   = 1'b0;
                  state_in = ST_RESULT;
               end else begin
                  inb_in   = 1'b1;
                  state_in = ST_ADDR;
               end
            end
         end
         ST_ADDR: begin
            addr_in  = idx_full[AW-1:0];
            state_in = ST_READ;
         end
         ST_READ: begin
            // Stored pixel is registered at the end of this cycle.
            state_in = ST_WEIGHT;
         end
         ST_WEIGHT: begin
            ws_in    = {sa_ff, 8'd0} - {8'd0, sa_ff};
            wd_in    = 16'(rd_data_ff[7:0]) * 16'(8'd255 - sa_ff);
            chan_in  = CH_BLUE;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            s_in = s_sum;
            if (s_sum == 16'd0) begin
               // Both alphas zero: the color stays as stored.
               case (chan_ff)
                  CH_BLUE:  nb_in = d_sel;
                  CH_GREEN: ng_in = d_sel;
                  default:  nr_in = d_sel;
               endcase
               if (chan_ff == CH_RED) begin
                  state_in = ST_RESULT;
               end else begin
                  chan_in = chan_type'(chan_ff + 2'd1);
               end
            end else begin
               rem_in   = num[23:8];
               bits_in  = num[7:0];
               step_in  = 2'd0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = r2[15:0];
            bits_in = {bits_ff[5:0], 2'b00};
            q_in    = {q_ff[5:0], qa, qb};
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               case (chan_ff)
                  CH_BLUE:  nb_in = q_in;
                  CH_GREEN: ng_in = q_in;
                  default:  nr_in = q_in;
               endcase
               if (chan_ff == CH_RED) begin
                  state_in = ST_RESULT;
               end else begin
                  chan_in  = chan_type'(chan_ff + 2'd1);
                  state_in = ST_NUM;
               end
            end
         end
         ST_FILL: begin
            if (cnt_ff == fill_n_ff) begin
               state_in = ST_RESULT;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = src_px;
               cnt_in    = cnt_ff + CW'(1);
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = inb_ff;
               state_in     = ST_IDLE;
               if (kind_ff == KIND_CLEAR) begin
                  rsp_data_in = {sb_ff, sg_ff, sr_ff, sa_ff};
               end else if (!inb_ff) begin
                  rsp_data_in = 32'd0;
               end else begin
                  rsp_data_in = {nb_ff, ng_ff, nr_ff, na_full[RECIP_SHIFT +: 8]};
                  mem_we      = 1'b1;
                  mem_waddr   = addr_ff;
                  mem_wdata   = {nr_ff, ng_ff, nb_ff, na_full[RECIP_SHIFT +: 8]};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A size write clears the whole store.
      if (csr_we) begin
         if (csr_index == REG_FRAME_WIDTH) begin
            width_in = csr_wdata;
            cnt_in   = '0;
            state_in = ST_WIPE;
         end else if (csr_index == REG_FRAME_HEIGHT) begin
            height_in = csr_wdata;
            cnt_in    = '0;
            state_in  = ST_WIPE;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         cnt_ff       <= '0;
         width_ff     <= SIZE_RESET;
         height_ff    <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      fill_n_ff   <= fill_n_in;
      kind_ff     <= kind_in;
      inb_ff      <= inb_in;
      sa_ff       <= sa_in;
      sr_ff       <= sr_in;
      sg_ff       <= sg_in;
      sb_ff       <= sb_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      addr_ff     <= addr_in;
      ws_ff       <= ws_in;
      wd_ff       <= wd_in;
      s_ff        <= s_in;
      rem_ff      <= rem_in;
      bits_ff     <= bits_in;
      q_ff        <= q_in;
      step_ff     <= step_in;
      chan_ff     <= chan_in;
      nb_ff       <= nb_in;
      ng_ff       <= ng_in;
      nr_ff       <= nr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[addr_ff];
   end

endmodule
